>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define C2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define C2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// shared types and constants of the rectangular to polar converter
// ----------------------------------------------------------------------------
package c2p_pkg;

  // guard bits below the coordinate lsb in the rotation datapath
  localparam int GUARD = 16;
  // angle accumulator width, units of 2^-30 rad
  localparam int ZW = 32;
  // accumulator to output angle scale, 2^-30 rad -> 2^-14 rad
  localparam int ANG_SHIFT = 16;
  localparam int RAD_W = 16;
  localparam int ANG_W = 16;
  // pi/2 in units of 2^-14 rad
  localparam logic [ANG_W-1:0] HALF_PI_MAG = 16'd25736;

  typedef logic [RAD_W-1:0]        radius_t;
  typedef logic signed [ANG_W-1:0] angle_t;

  // special case flags carried alongside each transaction
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic y_pos;
  } c2p_flags_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 32'sd843314857;
      1:       val = 32'sd497837829;
      2:       val = 32'sd263043837;
      3:       val = 32'sd133525159;
      4:       val = 32'sd67021687;
      5:       val = 32'sd33543516;
      6:       val = 32'sd16775851;
      7:       val = 32'sd8388437;
      8:       val = 32'sd4194283;
      9:       val = 32'sd2097149;
      10:      val = 32'sd1048576;
      11:      val = 32'sd524288;
      12:      val = 32'sd262144;
      13:      val = 32'sd131072;
      14:      val = 32'sd65536;
      15:      val = 32'sd32768;
      16:      val = 32'sd16384;
      17:      val = 32'sd8192;
      18:      val = 32'sd4096;
      19:      val = 32'sd2048;
      20:      val = 32'sd1024;
      21:      val = 32'sd512;
      22:      val = 32'sd256;
      23:      val = 32'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> sv/c2p_in_if.sv
// ----------------------------------------------------------------------------
// c2p_in_if
// point channel: valid/ready handshake carrying one (x, y) coordinate pair
// ----------------------------------------------------------------------------
interface c2p_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

>>> sv/c2p_out_if.sv
// ----------------------------------------------------------------------------
// c2p_out_if
// polar channel: valid/ready handshake carrying one (radius, angle) pair
// ----------------------------------------------------------------------------
interface c2p_out_if
  import c2p_pkg::*;
();
  logic    valid;
  logic    ready;
  radius_t radius;
  angle_t  angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

>>> sv/cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar
//
// Converts a point (x, y) to its radius, round(sqrt(x*x + y*y)), and its
// half-plane angle atan(y/x) in [-pi/2, pi/2], scaled by 2^14 per radian.
// One transaction is accepted every clock cycle unless an output stall has
// backed up to the input. The path runs through one register for sign
// handling, one for the two squarers, one for the sum of squares, one stage
// per CORDIC rotation and restoring square root bit running side by side,
// and the output register.
// Stalls on the output back up through the pipeline stage by stage, so
// empty stages keep filling while a result waits. Points on the y axis
// give +/-pi/2, points on the x axis and the origin give angle 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_polar
  import c2p_pkg::*;
#(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  c2p_in_if.sink     in_ch,
  c2p_out_if.source  out_ch
);

  localparam int CW    = COORD_WIDTH;
  localparam int SUM_W = 2 * CW;
  localparam int RT_W  = SUM_W + 1;
  localparam int CDW   = CW + GUARD + 3;
  localparam int NSTEP = (ITERATIONS > CW) ? ITERATIONS : CW;
  localparam logic [ZW:0] Z_HALF = (ZW + 1)'(1) << (ANG_SHIFT - 1);

  // stage 0: sign handling
  logic                  v0_r;
  logic [CW-1:0]         ax0_r, ay0_r;
  logic signed [CDW-1:0] cx0_r, cy0_r;
  c2p_flags_t            fl0_r;

  // stage 1: squares
  logic                  v1_r;
  logic [SUM_W-1:0]      sqx1_r, sqy1_r;
  logic signed [CDW-1:0] cx1_r, cy1_r;
  c2p_flags_t            fl1_r;

  // step stages, entry 0 holds the sum of squares, entry j+1 follows step j
  logic                  vs_r  [NSTEP+1];
  logic signed [CDW-1:0] cx_r  [NSTEP+1];
  logic signed [CDW-1:0] cy_r  [NSTEP+1];
  logic signed [ZW-1:0]  z_r   [NSTEP+1];
  logic [SUM_W-1:0]      rem_r [NSTEP+1];
  logic [RT_W-1:0]       rt_r  [NSTEP+1];
  c2p_flags_t            fl_r  [NSTEP+1];

  // output register
  logic                  out_valid_r;
  radius_t               out_radius_r;
  angle_t                out_angle_r;

  // per-stage load enables
  logic                  rdy0, rdy1, rdy_o;
  logic                  rdy_s [NSTEP+1];

  // ready chain: a stage loads when empty or when its content moves on
  assign rdy_o         = !out_valid_r || out_ch.ready;
  assign rdy_s[NSTEP]  = !vs_r[NSTEP] || rdy_o;
  for (genvar k = 0; k < NSTEP; k++) begin : g_rdy
    assign rdy_s[k] = !vs_r[k] || rdy_s[k+1];
  end
  assign rdy1        = !v1_r || rdy_s[0];
  assign rdy0        = !v0_r || rdy1;
  assign in_ch.ready = rdy0;

  // stage 0: magnitudes, reflection of the left half plane, flags
  logic                  neg_x;
  logic [CW-1:0]         ax_nxt, ay_nxt;
  logic signed [CDW-1:0] xe, ye;
  logic signed [CDW-1:0] cx0_nxt, cy0_nxt;
  c2p_flags_t            fl0_nxt;

  always_comb begin
    neg_x   = in_ch.x_in[CW-1];
    ax_nxt  = neg_x ? CW'(~in_ch.x_in + 1'b1) : in_ch.x_in;
    ay_nxt  = in_ch.y_in[CW-1] ? CW'(~in_ch.y_in + 1'b1) : in_ch.y_in;
    xe      = {{(CDW-CW){in_ch.x_in[CW-1]}}, in_ch.x_in};
    ye      = {{(CDW-CW){in_ch.y_in[CW-1]}}, in_ch.y_in};
    cx0_nxt = (neg_x ? -xe : xe) <<< GUARD;
    cy0_nxt = (neg_x ? -ye : ye) <<< GUARD;
    fl0_nxt.y_zero = (in_ch.y_in == '0);
    fl0_nxt.x_zero = (in_ch.x_in == '0);
    fl0_nxt.y_pos  = !in_ch.y_in[CW-1] && (in_ch.y_in != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      ax0_r <= ax_nxt;
      ay0_r <= ay_nxt;
      cx0_r <= cx0_nxt;
      cy0_r <= cy0_nxt;
      fl0_r <= fl0_nxt;
    end
  end

  // stage 1: squarers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sqx1_r <= SUM_W'(ax0_r) * SUM_W'(ax0_r);
      sqy1_r <= SUM_W'(ay0_r) * SUM_W'(ay0_r);
      cx1_r  <= cx0_r;
      cy1_r  <= cy0_r;
      fl1_r  <= fl0_r;
    end
  end

  // stage 2: sum of squares seeds the square root, angle accumulator cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (rdy_s[0]) begin
      vs_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[0]) begin
      rem_r[0] <= sqx1_r + sqy1_r;
      rt_r[0]  <= '0;
      cx_r[0]  <= cx1_r;
      cy_r[0]  <= cy1_r;
      z_r[0]   <= '0;
      fl_r[0]  <= fl1_r;
    end
  end

  // step stages: a cordic rotation in each of the first ITERATIONS, a square root bit in each of the first COORD_WIDTH
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic signed [CDW-1:0] cx_nxt, cy_nxt;
    logic signed [ZW-1:0]  z_nxt;
    logic [SUM_W-1:0]      rem_nxt;
    logic [RT_W-1:0]       rt_nxt;

    if (j < ITERATIONS) begin : g_rot
      // rotate toward the x axis, direction from the sign of y
      always_comb begin
        if (!cy_r[j][CDW-1]) begin
          cx_nxt = cx_r[j] + (cy_r[j] >>> j);
          cy_nxt = cy_r[j] - (cx_r[j] >>> j);
          z_nxt  = z_r[j] + atan_entry(j);
        end else begin
          cx_nxt = cx_r[j] - (cy_r[j] >>> j);
          cy_nxt = cy_r[j] + (cx_r[j] >>> j);
          z_nxt  = z_r[j] - atan_entry(j);
        end
      end
    end else begin : g_rot_pass
      assign cx_nxt = cx_r[j];
      assign cy_nxt = cy_r[j];
      assign z_nxt  = z_r[j];
    end

    if (j < CW) begin : g_sqrt
      // restoring square root, one result bit per stage
      localparam logic [RT_W-1:0] SQ_BIT = RT_W'(1) << (2 * (CW - 1 - j));
      logic [RT_W-1:0] trial;
      always_comb begin
        trial = rt_r[j] + SQ_BIT;
        if (RT_W'(rem_r[j]) >= trial) begin
          rem_nxt = rem_r[j] - SUM_W'(trial);
          rt_nxt  = (rt_r[j] >> 1) + SQ_BIT;
        end else begin
          rem_nxt = rem_r[j];
          rt_nxt  = rt_r[j] >> 1;
        end
      end
    end else begin : g_sqrt_pass
      assign rem_nxt = rem_r[j];
      assign rt_nxt  = rt_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j+1] <= 1'b0;
      end else if (rdy_s[j+1]) begin
        vs_r[j+1] <= vs_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_s[j+1]) begin
        cx_r[j+1]  <= cx_nxt;
        cy_r[j+1]  <= cy_nxt;
        z_r[j+1]   <= z_nxt;
        rem_r[j+1] <= rem_nxt;
        rt_r[j+1]  <= rt_nxt;
        fl_r[j+1]  <= fl_r[j];
      end
    end
  end

  // output stage: angle rounding, clamp and special cases, radius rounding
  logic [ZW-1:0]    zmag;
  logic [ZW:0]      zq;
  logic [ANG_W-1:0] ang_mag;
  angle_t           angle_nxt;
  logic             rad_up;
  logic [CW-1:0]    root;
  logic [CW+RAD_W-1:0] root_ext;
  radius_t          radius_nxt;

  always_comb begin
    zmag    = z_r[NSTEP][ZW-1] ? -z_r[NSTEP] : z_r[NSTEP];
    zq      = ({1'b0, zmag} + Z_HALF) >> ANG_SHIFT;
    ang_mag = (zq > (ZW + 1)'(HALF_PI_MAG)) ? HALF_PI_MAG : zq[ANG_W-1:0];
    if (fl_r[NSTEP].y_zero) begin
      angle_nxt = '0;
    end else if (fl_r[NSTEP].x_zero) begin
      angle_nxt = fl_r[NSTEP].y_pos ? $signed(HALF_PI_MAG) : -$signed(HALF_PI_MAG);
    end else if (z_r[NSTEP][ZW-1]) begin
      angle_nxt = -$signed(ang_mag);
    end else begin
      angle_nxt = $signed(ang_mag);
    end

    // round up when the remainder exceeds the root
    rad_up     = RT_W'(rem_r[NSTEP]) > rt_r[NSTEP];
    root       = CW'(rt_r[NSTEP]) + CW'(rad_up);
    root_ext   = (CW + RAD_W)'(root);
    radius_nxt = root_ext[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= vs_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_radius_r <= radius_nxt;
      out_angle_r  <= angle_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.radius = out_radius_r;
  assign out_ch.angle  = out_angle_r;

  // angle stays within the half plane
  `C2P_ASSERT_NOW(a_angle_range, out_valid_r, (out_angle_r <= $signed(HALF_PI_MAG)) && (out_angle_r >= -$signed(HALF_PI_MAG)), "angle outside [-pi/2, pi/2]")

  // a point on the x axis leaves with angle zero
  `C2P_ASSERT_NEXT(a_yzero_angle, rdy_o && vs_r[NSTEP] && fl_r[NSTEP].y_zero, out_angle_r == '0, "zero y gave nonzero angle")

  // square root remainder never exceeds twice the root
  `C2P_ASSERT_NOW(a_sqrt_rem, vs_r[NSTEP], RT_W'(rem_r[NSTEP]) <= (rt_r[NSTEP] << 1), "square root remainder too large")

  // a stalled last step stage keeps its transaction
  `C2P_ASSERT_NEXT(a_stall_hold, vs_r[NSTEP] && !rdy_s[NSTEP], vs_r[NSTEP] && $stable(z_r[NSTEP]) && $stable(rt_r[NSTEP]), "stalled stage lost its transaction")

endmodule
